// ----- sv/bdph_pkg.sv -----
// Package for the press/hold button debouncer.
// Types, register indexes and code constants; no dependencies.
package bdph_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] CodeIdle = 16'h0000;
  localparam logic [15:0] CodeFirst = 16'h0001;
  localparam logic [15:0] CodeRestart = 16'h0002;
  localparam logic [15:0] CodeWrap = 16'hfffe;
  localparam logic [15:0] CodeRelease = 16'hffff;
  localparam logic [7:0] DelayReset = 8'd10;
  localparam logic [15:0] HoldReset = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE_MS = 8'd0,
    REG_HOLD_EXTRA = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] settle_ms;
    logic [15:0] hold_extra;
  } cfg_t;

  typedef struct packed {
    logic prev_level;
    logic [31:0] change_time;
    logic [15:0] code;
  } state_t;

  typedef struct packed {
    logic just_pressed;
    logic just_released;
    logic is_held;
    logic [15:0] press_code;
  } result_t;

endpackage

// ----- sv/bdph_cfg.sv -----
// Configuration register bank for the debouncer.
// Depends on bdph_pkg.
module bdph_cfg (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bdph_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bdph_pkg::CfgDataW-1:0] cfg_data,
  output bdph_pkg::cfg_t cfg
);
  import bdph_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETTLE_MS:  cfg_nxt.settle_ms = cfg_data[7:0];
        REG_HOLD_EXTRA: cfg_nxt.hold_extra = cfg_data[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms <= DelayReset;
      cfg_r.hold_extra <= HoldReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/bdph_update.sv -----
// Next-state and flag logic for one sample: settling timer, press code step.
// Depends on bdph_pkg.
module bdph_update (
  input  bdph_pkg::cfg_t cfg,
  input  bdph_pkg::state_t st,
  input  logic pin_level,
  input  logic [31:0] now_ms,
  output bdph_pkg::state_t st_nxt,
  output bdph_pkg::result_t res
);
  import bdph_pkg::*;

  logic [31:0] start_time;
  logic [31:0] elapsed;
  logic settled;
  logic [15:0] code_nxt;
  logic [16:0] held_limit;

  assign start_time = (pin_level != st.prev_level) ? now_ms : st.change_time;
  assign elapsed = now_ms - start_time;
  assign settled = elapsed > {24'd0, cfg.settle_ms};

  always_comb begin
    code_nxt = st.code;
    if (settled) begin
      if (!pin_level) begin
        if (st.code < CodeWrap) begin
          code_nxt = st.code + 16'd1;
        end else if (st.code == CodeWrap) begin
          code_nxt = CodeRestart;
        end
      end else if (st.code != CodeIdle) begin
        code_nxt = (st.code == CodeRelease) ? CodeIdle : CodeRelease;
      end
    end
  end

  assign st_nxt.prev_level = pin_level;
  assign st_nxt.change_time = start_time;
  assign st_nxt.code = code_nxt;

  assign held_limit = {1'b0, cfg.hold_extra} + 17'd1;
  assign res.just_pressed = code_nxt == CodeFirst;
  assign res.just_released = code_nxt == CodeRelease;
  assign res.is_held = ({1'b0, code_nxt} > held_limit) && (code_nxt != CodeRelease);
  assign res.press_code = code_nxt;

endmodule

// ----- sv/button_debounce_press_hold.sv -----
// Press/hold debouncer top level: input register, state and result register.
// Depends on bdph_pkg, bdph_cfg and bdph_update.
// One pin sample is taken per cycle while in_stall is low; its result passes
// through the input register, then the result register. The state update, a
// 32-bit timestamp subtract and compare followed by a 16-bit code step, is
// combinational between them. in_stall rises only while both registers hold a
// request and out_stall is high. cfg_ready is always high; write the
// registers only while no sample is in flight.
module button_debounce_press_hold (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_pin_level,
  input  logic [31:0] in_now_ms,
  output logic out_valid,
  input  logic out_stall,
  output logic out_just_pressed,
  output logic out_just_released,
  output logic out_is_held,
  output logic [15:0] out_press_code,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bdph_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bdph_pkg::CfgDataW-1:0] cfg_data
);
  import bdph_pkg::*;

  cfg_t cfg;
  state_t st_r;
  state_t st_nxt;
  result_t res_nxt;
  result_t res_r;

  logic in_valid_r;
  logic in_level_r;
  logic [31:0] in_now_r;
  logic out_valid_r;
  logic out_free;
  logic advance;
  logic in_take;

  bdph_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdph_update u_update (
    .cfg       (cfg),
    .st        (st_r),
    .pin_level (in_level_r),
    .now_ms    (in_now_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level_r <= in_pin_level;
      in_now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.prev_level <= 1'b1;
      st_r.change_time <= 32'd0;
      st_r.code <= CodeIdle;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_just_pressed = res_r.just_pressed;
  assign out_just_released = res_r.just_released;
  assign out_is_held = res_r.is_held;
  assign out_press_code = res_r.press_code;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("in_stall without both stages occupied");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("request lost between stages");

  a_idle_leaves_to_first: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.code == CodeIdle) |=> (st_r.code == CodeIdle || st_r.code == CodeFirst))
    else $error("idle code left to other than first press");

  a_release_leaves_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.code == CodeRelease) |=> (st_r.code == CodeRelease || st_r.code == CodeIdle))
    else $error("release code left to other than idle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.is_held && (res_r.just_pressed || res_r.just_released)))
    else $error("held flag overlaps press or release");

endmodule
